/* sv/linsfr_pkg.sv */
// Package for the LIN slave frame receiver: widths, protocol constants, status and
// phase codes, the shared item/result/configuration structs and the PID parity function.
// Depends on nothing; every other file of the block refers to it by scoped names.
package linsfr_pkg;

  localparam int unsigned DEF_MAX_DATA_BYTES = 8;
  localparam int unsigned BYTE_W             = 8;
  localparam int unsigned LEN_W              = 4;
  localparam int unsigned MASK_W             = 64;
  localparam int unsigned FRAME_W            = 64;
  localparam int unsigned CFG_IDX_W          = 3;
  localparam int unsigned CFG_DATA_W         = 64;
  localparam int unsigned ID_W               = 6;

  localparam logic [BYTE_W-1:0] BREAK_BYTE  = 8'h00;
  localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'h55;
  localparam logic [BYTE_W-1:0] TICK_SAT    = 8'hFF;
  localparam logic [BYTE_W-1:0] DEF_TIMEOUT = 8'd20;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TIMEOUT   = 3'd0;
  localparam cfg_idx_t CFG_RX_MASK   = 3'd1;
  localparam cfg_idx_t CFG_RESP_MASK = 3'd2;
  localparam cfg_idx_t CFG_LEN0_MASK = 3'd3;
  localparam cfg_idx_t CFG_LEN1_MASK = 3'd4;
  localparam cfg_idx_t CFG_LEN2_MASK = 3'd5;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_RESPOND    = 3'd1,
    ST_BAD_BREAK  = 3'd2,
    ST_BAD_SYNC   = 3'd3,
    ST_PARITY     = 3'd4,
    ST_CHECKSUM   = 3'd5,
    ST_TIMEOUT    = 3'd6,
    ST_UNKNOWN_ID = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SYNC = 3'd1,
    PH_PID  = 3'd2,
    PH_DATA = 3'd3,
    PH_CSUM = 3'd4
  } phase_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] rx_byte;
    logic              framing_error;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] timeout_ticks;
    logic [MASK_W-1:0] rx_mask;
    logic [MASK_W-1:0] resp_mask;
    logic [MASK_W-1:0] len0_mask;
    logic [MASK_W-1:0] len1_mask;
    logic [MASK_W-1:0] len2_mask;
  } cfg_t;

  typedef struct packed {
    status_t            status;
    logic [BYTE_W-1:0]  protected_id;
    logic [LEN_W-1:0]   data_length;
    logic [FRAME_W-1:0] frame_data;
  } result_t;

  // P0 = ID0^ID1^ID2^ID4 and P1 = !(ID1^ID3^ID4^ID5) sit in bits 6 and 7.
  function automatic logic parity_ok(input logic [BYTE_W-1:0] pid);
    logic p0;
    logic p1;
    p0 = pid[0] ^ pid[1] ^ pid[2] ^ pid[4];
    p1 = ~(pid[1] ^ pid[3] ^ pid[4] ^ pid[5]);
    return (pid[6] == p0) && (pid[7] == p1);
  endfunction

endpackage

/* sv/linsfr_cfg_regs.sv */
// Configuration register file of the LIN slave frame receiver.
// Depends on linsfr_pkg for the register indexes and the cfg_t struct.
module linsfr_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               we_i,
  input  linsfr_pkg::cfg_idx_t               index_i,
  input  logic [linsfr_pkg::CFG_DATA_W-1:0]  wdata_i,
  output linsfr_pkg::cfg_t                   cfg_o
);

  linsfr_pkg::cfg_t cfg_r;
  linsfr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we_i) begin
      unique case (index_i)
        linsfr_pkg::CFG_TIMEOUT:   cfg_nxt.timeout_ticks = wdata_i[linsfr_pkg::BYTE_W-1:0];
        linsfr_pkg::CFG_RX_MASK:   cfg_nxt.rx_mask       = wdata_i;
        linsfr_pkg::CFG_RESP_MASK: cfg_nxt.resp_mask     = wdata_i;
        linsfr_pkg::CFG_LEN0_MASK: cfg_nxt.len0_mask     = wdata_i;
        linsfr_pkg::CFG_LEN1_MASK: cfg_nxt.len1_mask     = wdata_i;
        linsfr_pkg::CFG_LEN2_MASK: cfg_nxt.len2_mask     = wdata_i;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{timeout_ticks: linsfr_pkg::DEF_TIMEOUT, rx_mask: '0, resp_mask: '0,
                 len0_mask: '0, len1_mask: '0, len2_mask: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

/* sv/linsfr_in_reg.sv */
// Input register stage of the LIN slave frame receiver: captures one transaction and
// holds it until the frame logic takes it. Depends on linsfr_pkg for item_t.
module linsfr_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  linsfr_pkg::item_t   in_item_i,
  output logic                item_valid_o,
  output linsfr_pkg::item_t   item_o,
  input  logic                take_i
);

  logic              valid_r;
  logic              valid_nxt;
  linsfr_pkg::item_t item_r;

  // A held item that is taken this cycle frees the register for the next one.
  assign in_ready_o = !valid_r || take_i;
  assign valid_nxt  = (in_valid_i && in_ready_o) || (valid_r && !take_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_i && in_ready_o) begin
      item_r <= in_item_i;
    end
  end

  assign item_valid_o = valid_r;
  assign item_o       = item_r;

endmodule

/* sv/linsfr_frame_fsm.sv */
// Frame state machine of the LIN slave frame receiver: break/sync/PID checks, data
// capture, classic checksum and timeout. Depends on linsfr_pkg.
module linsfr_frame_fsm #(
  parameter int unsigned MAX_DATA_BYTES = linsfr_pkg::DEF_MAX_DATA_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid_i,
  input  linsfr_pkg::item_t   item_i,
  input  linsfr_pkg::cfg_t    cfg_i,
  input  logic                res_room_i,
  output logic                take_o,
  output logic                res_valid_o,
  output linsfr_pkg::result_t res_o
);

  localparam int unsigned             BW      = linsfr_pkg::BYTE_W;
  localparam int unsigned             LW      = linsfr_pkg::LEN_W;
  localparam logic [LW-1:0]           MAX_LEN = LW'(MAX_DATA_BYTES);

  linsfr_pkg::phase_t phase_r, phase_nxt;
  logic [LW-1:0]      idx_r, idx_nxt;
  logic [BW-1:0]      id_r, id_nxt;
  logic [LW-1:0]      exp_len_r, exp_len_nxt;
  logic [MAX_DATA_BYTES-1:0][BW-1:0] store_r, store_nxt;
  logic [BW-1:0]      sum_r, sum_nxt;
  logic [BW-1:0]      tick_r, tick_nxt;

  logic                            go;
  logic                            finish;
  logic                            good;
  linsfr_pkg::status_t             status;
  logic [BW-1:0]                   id_rpt;
  logic [linsfr_pkg::ID_W-1:0]     fid;
  logic [LW-1:0]                   len_full;
  logic [LW-1:0]                   len_sat;
  logic [BW:0]                     sum9;
  logic [BW-1:0]                   sum_add;
  logic [BW-1:0]                   tick_inc;
  logic [LW-1:0]                   idx_inc;

  assign go     = item_valid_i && res_room_i;
  assign take_o = go;

  assign fid      = item_i.rx_byte[linsfr_pkg::ID_W-1:0];
  assign len_full = {1'b0, cfg_i.len2_mask[fid], cfg_i.len1_mask[fid], cfg_i.len0_mask[fid]}
                    + LW'(1);
  assign len_sat  = (len_full > MAX_LEN) ? MAX_LEN : len_full;
  // End-around carry: a carry out of bit 7 comes back in at bit 0.
  assign sum9     = {1'b0, sum_r} + {1'b0, item_i.rx_byte};
  assign sum_add  = sum9[BW-1:0] + BW'(sum9[BW]);
  assign tick_inc = (tick_r != linsfr_pkg::TICK_SAT) ? tick_r + BW'(1) : tick_r;
  assign idx_inc  = idx_r + LW'(1);

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    id_nxt      = id_r;
    exp_len_nxt = exp_len_r;
    store_nxt   = store_r;
    sum_nxt     = sum_r;
    tick_nxt    = tick_r;
    finish      = 1'b0;
    good        = 1'b0;
    status      = linsfr_pkg::ST_OK;
    id_rpt      = id_r;

    if (go) begin
      if (item_i.kind == linsfr_pkg::KIND_TICK) begin
        if (phase_r != linsfr_pkg::PH_IDLE) begin
          tick_nxt = tick_inc;
          if (tick_inc >= cfg_i.timeout_ticks) begin
            finish = 1'b1;
            status = linsfr_pkg::ST_TIMEOUT;
          end
        end
      end else begin
        unique case (phase_r)
          linsfr_pkg::PH_IDLE: begin
            if (item_i.rx_byte == linsfr_pkg::BREAK_BYTE && item_i.framing_error) begin
              tick_nxt  = '0;
              phase_nxt = linsfr_pkg::PH_SYNC;
            end else begin
              finish = 1'b1;
              status = linsfr_pkg::ST_BAD_BREAK;
            end
          end
          linsfr_pkg::PH_SYNC: begin
            if (item_i.rx_byte == linsfr_pkg::SYNC_BYTE) begin
              phase_nxt = linsfr_pkg::PH_PID;
            end else begin
              finish = 1'b1;
              status = linsfr_pkg::ST_BAD_SYNC;
            end
          end
          linsfr_pkg::PH_PID: begin
            id_nxt = item_i.rx_byte;
            id_rpt = item_i.rx_byte;
            if (!linsfr_pkg::parity_ok(item_i.rx_byte)) begin
              finish = 1'b1;
              status = linsfr_pkg::ST_PARITY;
            end else if (cfg_i.rx_mask[fid]) begin
              // A receive id wins over a respond id.
              exp_len_nxt = len_sat;
              idx_nxt     = '0;
              sum_nxt     = '0;
              phase_nxt   = linsfr_pkg::PH_DATA;
            end else if (cfg_i.resp_mask[fid]) begin
              finish = 1'b1;
              status = linsfr_pkg::ST_RESPOND;
            end else begin
              finish = 1'b1;
              status = linsfr_pkg::ST_UNKNOWN_ID;
            end
          end
          linsfr_pkg::PH_DATA: begin
            for (int i = 0; i < MAX_DATA_BYTES; i++) begin
              if (idx_r == LW'(i)) begin
                store_nxt[i] = item_i.rx_byte;
              end
            end
            sum_nxt = sum_add;
            idx_nxt = idx_inc;
            if (idx_inc >= exp_len_r) begin
              phase_nxt = linsfr_pkg::PH_CSUM;
            end
          end
          linsfr_pkg::PH_CSUM: begin
            finish = 1'b1;
            if (item_i.rx_byte == ~sum_r) begin
              good   = 1'b1;
              status = linsfr_pkg::ST_OK;
            end else begin
              status = linsfr_pkg::ST_CHECKSUM;
            end
          end
          default: begin
            phase_nxt = linsfr_pkg::PH_IDLE;
          end
        endcase
      end

      // Every frame end returns the whole frame state to its reset value.
      if (finish) begin
        phase_nxt   = linsfr_pkg::PH_IDLE;
        idx_nxt     = '0;
        id_nxt      = '0;
        exp_len_nxt = '0;
        store_nxt   = '0;
        sum_nxt     = '0;
        tick_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= linsfr_pkg::PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      id_r      <= '0;
      exp_len_r <= '0;
      store_r   <= '0;
      sum_r     <= '0;
      tick_r    <= '0;
    end else begin
      idx_r     <= idx_nxt;
      id_r      <= id_nxt;
      exp_len_r <= exp_len_nxt;
      store_r   <= store_nxt;
      sum_r     <= sum_nxt;
      tick_r    <= tick_nxt;
    end
  end

  assign res_valid_o        = go && finish;
  assign res_o.status       = status;
  assign res_o.protected_id = id_rpt;
  assign res_o.data_length  = good ? exp_len_r : '0;
  assign res_o.frame_data   = good ? linsfr_pkg::FRAME_W'(store_r) : '0;

endmodule

/* sv/linsfr_out_reg.sv */
// Result register stage of the LIN slave frame receiver: holds one status transaction
// until the consumer takes it. Depends on linsfr_pkg for result_t.
module linsfr_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid_i,
  input  linsfr_pkg::result_t res_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output linsfr_pkg::result_t out_res_o
);

  logic                valid_r;
  logic                valid_nxt;
  linsfr_pkg::result_t res_r;

  assign room_o    = !valid_r || out_ready_i;
  assign valid_nxt = (res_valid_i && room_o) || (valid_r && !out_ready_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid_i && room_o) begin
      res_r <= res_i;
    end
  end

  assign out_valid_o = valid_r;
  assign out_res_o   = res_r;

endmodule

/* sv/lin_slave_frame_receiver.sv */
// LIN slave frame receiver, top level: input register, frame state machine, result
// register and configuration registers. Depends on linsfr_pkg and the linsfr_* modules.
//
// The block watches a stream of LIN bus transactions, each either a byte from the UART
// (with its framing error flag) or a timer tick, and reports one status transaction per
// frame. A frame must open with a break (0x00 with a framing error), then the sync byte
// 0x55, then a protected id whose P0/P1 parity bits are checked. The low six id bits
// select a bit in each mask register: a receive id takes 1 to MAX_DATA_BYTES data bytes
// (length minus one from the three length masks, saturated) followed by a classic
// checksum, the inverted end-around-carry sum of the data; a respond id ends the frame
// at once with status "respond"; an id in neither mask reports "unknown id". A receive
// id takes priority when both masks are set. Ticks are counted only inside a frame and
// the frame times out once the count reaches timeout_ticks. Every status transaction
// returns the block to idle; a byte that arrives in idle and is not a break reports
// "bad break". Data length and frame data are zero unless the status is ok.
// Throughput is one transaction per clock while the result register has room: a
// transaction is captured in the input register when it is accepted, then handled by
// the frame state machine, whose result is registered in the result register, from
// which the status of the frame is presented. While a status waits in the result
// register and the consumer is not ready, the frame logic takes nothing, so the input
// side accepts at most the one transaction that fills the input register and then
// stalls until the status is taken.
// Configuration must be written while no frame transaction is in flight.
module lin_slave_frame_receiver #(
  parameter int unsigned MAX_DATA_BYTES = linsfr_pkg::DEF_MAX_DATA_BYTES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_kind,
  input  logic [linsfr_pkg::BYTE_W-1:0]      in_rx_byte,
  input  logic                               in_framing_error,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         out_status,
  output logic [linsfr_pkg::BYTE_W-1:0]      out_protected_id,
  output logic [linsfr_pkg::LEN_W-1:0]       out_data_length,
  output logic [linsfr_pkg::FRAME_W-1:0]     out_frame_data,
  input  logic                               cfg_we,
  input  logic [linsfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [linsfr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  linsfr_pkg::item_t   in_item;
  linsfr_pkg::item_t   item;
  logic                item_valid;
  logic                take;
  linsfr_pkg::cfg_t    cfg;
  logic                res_valid;
  linsfr_pkg::result_t res;
  logic                res_room;
  linsfr_pkg::result_t out_res;

  assign in_item.kind          = in_kind;
  assign in_item.rx_byte       = in_rx_byte;
  assign in_item.framing_error = in_framing_error;

  linsfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .we_i    (cfg_we),
    .index_i (cfg_index),
    .wdata_i (cfg_wdata),
    .cfg_o   (cfg)
  );

  linsfr_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (take)
  );

  linsfr_frame_fsm #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid_i (item_valid),
    .item_i       (item),
    .cfg_i        (cfg),
    .res_room_i   (res_room),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  linsfr_out_reg u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid_i (res_valid),
    .res_i       (res),
    .room_o      (res_room),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_res_o   (out_res)
  );

  assign out_status       = out_res.status;
  assign out_protected_id = out_res.protected_id;
  assign out_data_length  = out_res.data_length;
  assign out_frame_data   = out_res.frame_data;

endmodule

/* sv/linsfr_checker.sv */
// Port-level checker for the LIN slave frame receiver, bound to the top level.
// Depends on linsfr_pkg for status codes and widths.
module linsfr_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [2:0]                         out_status,
  input logic [linsfr_pkg::BYTE_W-1:0]      out_protected_id,
  input logic [linsfr_pkg::LEN_W-1:0]       out_data_length,
  input logic [linsfr_pkg::FRAME_W-1:0]     out_frame_data
);

  // A waiting status transaction must not change under backpressure.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_protected_id) && $stable(out_data_length) && $stable(out_frame_data))
    else $error("result changed while stalled");

  // A good frame always carries between one and eight data bytes.
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == linsfr_pkg::ST_OK |->
      out_data_length != '0 && out_data_length <= linsfr_pkg::LEN_W'(8))
    else $error("ok frame with bad length");

  // Any failed or response frame delivers no data.
  a_err_nodata: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != linsfr_pkg::ST_OK |->
      out_data_length == '0 && out_frame_data == '0)
    else $error("data delivered with non-ok status");

  // Break and sync errors happen before any id byte is seen.
  a_early_noid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == linsfr_pkg::ST_BAD_BREAK
      || out_status == linsfr_pkg::ST_BAD_SYNC) |-> out_protected_id == '0)
    else $error("id reported before id byte");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lin_slave_frame_receiver linsfr_checker u_linsfr_checker (.*);

/* dv/lin_slave_frame_receiver_tb.sv */
// Self-checking testbench for the LIN slave frame receiver: directed frames, then random
// bus traffic under several register settings, checked against an in-bench frame predictor.
// Depends on linsfr_pkg and lin_slave_frame_receiver; needs no files or arguments.
`timescale 1ns / 100ps

module lin_slave_frame_receiver_tb;

  localparam int unsigned DATA_BYTES_MAX    = linsfr_pkg::DEF_MAX_DATA_BYTES;
  localparam int unsigned SETTLE_CYCLES     = 6;
  localparam int unsigned NUM_SETTINGS      = 8;
  localparam int unsigned ITEMS_PER_SETTING = 220;
  localparam int unsigned SCRIPT_ROWS       = 28;
  localparam int unsigned SCRIPT_RESET_ROWS = 10;

  // One row of the directed script. Rows with fixed set carry an expectation typed in
  // by hand; all other rows are checked against the predictor.
  typedef struct {
    logic                                kind;
    logic [linsfr_pkg::BYTE_W-1:0]       rx_byte;
    logic                                ferr;
    bit                                  fixed;
    linsfr_pkg::status_t                 status;
    logic [linsfr_pkg::BYTE_W-1:0]       pid;
    logic [linsfr_pkg::LEN_W-1:0]        len;
    logic [linsfr_pkg::FRAME_W-1:0]      data;
  } script_row_t;

  logic                                  clk;
  logic                                  rst_n            = 1'b0;
  logic                                  in_valid         = 1'b0;
  logic                                  in_ready;
  logic                                  in_kind          = linsfr_pkg::KIND_BYTE;
  logic [linsfr_pkg::BYTE_W-1:0]         in_rx_byte       = '0;
  logic                                  in_framing_error = 1'b0;
  logic                                  out_valid;
  logic                                  out_ready        = 1'b0;
  logic [2:0]                            out_status;
  logic [linsfr_pkg::BYTE_W-1:0]         out_protected_id;
  logic [linsfr_pkg::LEN_W-1:0]          out_data_length;
  logic [linsfr_pkg::FRAME_W-1:0]        out_frame_data;
  logic                                  cfg_we           = 1'b0;
  linsfr_pkg::cfg_idx_t                  cfg_index        = linsfr_pkg::CFG_TIMEOUT;
  logic [linsfr_pkg::CFG_DATA_W-1:0]     cfg_wdata        = '0;

  // Shadow of the configuration registers, kept in step with every write.
  linsfr_pkg::cfg_t shadow_cfg = '{timeout_ticks: linsfr_pkg::DEF_TIMEOUT, rx_mask: '0,
                                   resp_mask: '0, len0_mask: '0, len1_mask: '0,
                                   len2_mask: '0};

  // Predicted frame state of the receiver.
  linsfr_pkg::phase_t             frm_phase = linsfr_pkg::PH_IDLE;
  logic [linsfr_pkg::LEN_W-1:0]   frm_index = '0;
  logic [linsfr_pkg::BYTE_W-1:0]  frm_pid   = '0;
  logic [linsfr_pkg::LEN_W-1:0]   frm_len   = '0;
  logic [linsfr_pkg::BYTE_W-1:0]  frm_bytes [DATA_BYTES_MAX] = '{default: '0};
  logic [linsfr_pkg::BYTE_W-1:0]  frm_sum   = '0;
  logic [linsfr_pkg::BYTE_W-1:0]  frm_ticks = '0;

  // Status transactions predicted but not yet seen on the output, oldest first.
  linsfr_pkg::result_t awaited_results [$];

  script_row_t script [SCRIPT_ROWS];
  int unsigned items_done  = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches  = 0;
  int unsigned status_seen [8] = '{default: 0};
  bit          quiet       = 1'b0;

  lin_slave_frame_receiver u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_rx_byte       (in_rx_byte),
    .in_framing_error (in_framing_error),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_protected_id (out_protected_id),
    .out_data_length  (out_data_length),
    .out_frame_data   (out_frame_data),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A generous fixed ceiling on the run; a correct run ends far earlier.
  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

  // The protected id is the six id bits topped with P0 in bit 6 and P1, the inverted
  // parity of ID1, ID3, ID4 and ID5, in bit 7.
  function automatic logic [linsfr_pkg::BYTE_W-1:0] protect_id(
      input logic [linsfr_pkg::ID_W-1:0] id);
    return {~(id[1] ^ id[3] ^ id[4] ^ id[5]), id[0] ^ id[1] ^ id[2] ^ id[4], id};
  endfunction

  // Builds the status transaction that ends the current frame and returns the predicted
  // frame state to idle. Data and length are reported only for a good frame.
  function automatic linsfr_pkg::result_t close_frame(input linsfr_pkg::status_t st,
                                                      input bit good);
    linsfr_pkg::result_t r;
    r = '0;
    r.status       = st;
    r.protected_id = frm_pid;
    if (good) begin
      r.data_length = frm_len;
      for (int i = 0; i < DATA_BYTES_MAX && i < frm_len; i++)
        r.frame_data[8*i +: 8] = frm_bytes[i];
    end
    frm_phase = linsfr_pkg::PH_IDLE;
    frm_index = '0;
    frm_pid   = '0;
    frm_len   = '0;
    frm_bytes = '{default: '0};
    frm_sum   = '0;
    frm_ticks = '0;
    return r;
  endfunction

  // Advances the predicted frame state by one accepted transaction. Returns 1 when the
  // transaction ends a frame, with the expected status transaction in res.
  function automatic bit predict_frame_step(input logic kind,
                                            input logic [linsfr_pkg::BYTE_W-1:0] b,
                                            input logic ferr,
                                            output linsfr_pkg::result_t res);
    logic [linsfr_pkg::ID_W-1:0]   id;
    logic [linsfr_pkg::BYTE_W:0]   total;
    logic [linsfr_pkg::LEN_W-1:0]  need;
    bit                            done;
    bit                            good;
    linsfr_pkg::status_t           st;
    res  = '0;
    done = 1'b0;
    good = 1'b0;
    st   = linsfr_pkg::ST_OK;
    if (kind == linsfr_pkg::KIND_TICK) begin
      // Ticks only count inside a frame, and the count saturates.
      if (frm_phase == linsfr_pkg::PH_IDLE)
        return 1'b0;
      if (frm_ticks != linsfr_pkg::TICK_SAT)
        frm_ticks = frm_ticks + 1'b1;
      if (frm_ticks < shadow_cfg.timeout_ticks)
        return 1'b0;
      res = close_frame(linsfr_pkg::ST_TIMEOUT, 1'b0);
      return 1'b1;
    end
    case (frm_phase)
      linsfr_pkg::PH_IDLE: begin
        if (b == linsfr_pkg::BREAK_BYTE && ferr) begin
          frm_ticks = '0;
          frm_phase = linsfr_pkg::PH_SYNC;
        end else begin
          done = 1'b1;
          st   = linsfr_pkg::ST_BAD_BREAK;
        end
      end
      linsfr_pkg::PH_SYNC: begin
        if (b == linsfr_pkg::SYNC_BYTE) begin
          frm_phase = linsfr_pkg::PH_PID;
        end else begin
          done = 1'b1;
          st   = linsfr_pkg::ST_BAD_SYNC;
        end
      end
      linsfr_pkg::PH_PID: begin
        frm_pid = b;
        id      = b[linsfr_pkg::ID_W-1:0];
        if (b != protect_id(id)) begin
          done = 1'b1;
          st   = linsfr_pkg::ST_PARITY;
        end else if (shadow_cfg.rx_mask[id]) begin
          // A receive id wins even when its respond bit is also set.
          need = {1'b0, shadow_cfg.len2_mask[id], shadow_cfg.len1_mask[id],
                  shadow_cfg.len0_mask[id]} + 1'b1;
          if (need > DATA_BYTES_MAX)
            need = linsfr_pkg::LEN_W'(DATA_BYTES_MAX);
          frm_len   = need;
          frm_index = '0;
          frm_sum   = '0;
          frm_phase = linsfr_pkg::PH_DATA;
        end else begin
          done = 1'b1;
          st   = shadow_cfg.resp_mask[id] ? linsfr_pkg::ST_RESPOND
                                          : linsfr_pkg::ST_UNKNOWN_ID;
        end
      end
      linsfr_pkg::PH_DATA: begin
        // Classic checksum: an end-around-carry sum of the data bytes.
        frm_bytes[frm_index[2:0]] = b;
        total     = {1'b0, frm_sum} + b;
        frm_sum   = total[linsfr_pkg::BYTE_W-1:0] + total[linsfr_pkg::BYTE_W];
        frm_index = frm_index + 1'b1;
        if (frm_index >= frm_len)
          frm_phase = linsfr_pkg::PH_CSUM;
      end
      default: begin
        done = 1'b1;
        if (b == ~frm_sum) begin
          st   = linsfr_pkg::ST_OK;
          good = 1'b1;
        end else begin
          st = linsfr_pkg::ST_CHECKSUM;
        end
      end
    endcase
    if (done)
      res = close_frame(st, good);
    return done;
  endfunction

  // Presents one transaction, sometimes after a random gap, and holds it until it is
  // accepted. The prediction for it is handed back to the caller.
  task automatic drive_item(input logic kind, input logic [linsfr_pkg::BYTE_W-1:0] b,
                            input logic ferr, output bit got,
                            output linsfr_pkg::result_t res);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_rx_byte       <= b;
    in_framing_error <= ferr;
    do @(posedge clk); while (!in_ready);
    // A tick outside a frame is simply dropped by the block and is not counted.
    if (!(kind == linsfr_pkg::KIND_TICK && frm_phase == linsfr_pkg::PH_IDLE))
      items_done++;
    got = predict_frame_step(kind, b, ferr, res);
  endtask

  task automatic send_item(input logic kind, input logic [linsfr_pkg::BYTE_W-1:0] b,
                           input logic ferr);
    bit                  got;
    linsfr_pkg::result_t res;
    drive_item(kind, b, ferr, got, res);
    if (got)
      awaited_results.push_back(res);
  endtask

  // Stops sending, lets every awaited status arrive and then waits out the pipeline,
  // since the last transaction may have caused no status at all.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register. The write enable is left high so back-to-back writes do not
  // toggle it within one time step; the caller drops it after the last write.
  task automatic reg_write(input linsfr_pkg::cfg_idx_t idx,
                           input logic [linsfr_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      linsfr_pkg::CFG_TIMEOUT:   shadow_cfg.timeout_ticks = val[linsfr_pkg::BYTE_W-1:0];
      linsfr_pkg::CFG_RX_MASK:   shadow_cfg.rx_mask       = val;
      linsfr_pkg::CFG_RESP_MASK: shadow_cfg.resp_mask     = val;
      linsfr_pkg::CFG_LEN0_MASK: shadow_cfg.len0_mask     = val;
      linsfr_pkg::CFG_LEN1_MASK: shadow_cfg.len1_mask     = val;
      linsfr_pkg::CFG_LEN2_MASK: shadow_cfg.len2_mask     = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_regs(input linsfr_pkg::cfg_t c);
    reg_write(linsfr_pkg::CFG_TIMEOUT, linsfr_pkg::CFG_DATA_W'(c.timeout_ticks));
    reg_write(linsfr_pkg::CFG_RX_MASK, c.rx_mask);
    reg_write(linsfr_pkg::CFG_RESP_MASK, c.resp_mask);
    reg_write(linsfr_pkg::CFG_LEN0_MASK, c.len0_mask);
    reg_write(linsfr_pkg::CFG_LEN1_MASK, c.len1_mask);
    reg_write(linsfr_pkg::CFG_LEN2_MASK, c.len2_mask);
    cfg_we <= 1'b0;
  endtask

  // Mostly zero ticks, sometimes a few, and now and then a run of up to one tick more
  // than the timeout, which may reach it.
  task automatic sprinkle_ticks(input int unsigned tick_div);
    int unsigned burst;
    burst = 0;
    if ($urandom_range(0, 59) == 0)
      burst = $urandom_range(1, shadow_cfg.timeout_ticks + 1);
    else
      while ($urandom_range(0, tick_div) == 0) burst++;
    repeat (burst) send_item(linsfr_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
  endtask

  // One frame of random content. Most frames are well formed; a few carry a bad break,
  // a bad sync, a corrupt id or a wrong checksum, and ticks may cut any of them short.
  task automatic random_frame(input int unsigned tick_div);
    logic [linsfr_pkg::ID_W-1:0]   id;
    logic [linsfr_pkg::BYTE_W-1:0] b;
    int unsigned                   pick;
    sprinkle_ticks(tick_div);
    pick = $urandom_range(0, 19);
    if (pick == 0)
      send_item(linsfr_pkg::KIND_BYTE, 8'($urandom_range(1, 255)), 1'($urandom));
    else if (pick == 1)
      send_item(linsfr_pkg::KIND_BYTE, linsfr_pkg::BREAK_BYTE, 1'b0);
    else
      send_item(linsfr_pkg::KIND_BYTE, linsfr_pkg::BREAK_BYTE, 1'b1);
    sprinkle_ticks(tick_div);
    if ($urandom_range(0, 19) == 0)
      send_item(linsfr_pkg::KIND_BYTE, 8'($urandom), 1'($urandom));
    else
      send_item(linsfr_pkg::KIND_BYTE, linsfr_pkg::SYNC_BYTE,
                1'($urandom_range(0, 3) == 0));
    sprinkle_ticks(tick_div);
    id = linsfr_pkg::ID_W'($urandom);
    if ($urandom_range(0, 14) == 0)
      send_item(linsfr_pkg::KIND_BYTE, 8'($urandom), 1'($urandom));
    else
      send_item(linsfr_pkg::KIND_BYTE, protect_id(id), 1'($urandom_range(0, 3) == 0));
    while (frm_phase == linsfr_pkg::PH_DATA) begin
      sprinkle_ticks(tick_div);
      if (frm_phase == linsfr_pkg::PH_DATA) begin
        case ($urandom_range(0, 5))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = 8'($urandom);
        endcase
        send_item(linsfr_pkg::KIND_BYTE, b, 1'($urandom_range(0, 3) == 0));
      end
    end
    sprinkle_ticks(tick_div);
    if (frm_phase == linsfr_pkg::PH_CSUM) begin
      if ($urandom_range(0, 9) == 0)
        b = 8'($urandom);
      else
        b = ~frm_sum;
      send_item(linsfr_pkg::KIND_BYTE, b, 1'($urandom_range(0, 3) == 0));
    end
  endtask

  // The receiving side stalls in random bursts, except in the final setting.
  initial begin
    wait (rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Every status transaction is matched, field by field, against the oldest prediction.
  always @(posedge clk) begin : result_check
    linsfr_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      status_seen[out_status]++;
      if (awaited_results.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected status transaction: ", $realtime,
                   "st=%0d pid=%02h len=%0d data=%016h",
                   out_status, out_protected_id, out_data_length, out_frame_data);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status || out_protected_id !== want.protected_id ||
            out_data_length !== want.data_length || out_frame_data !== want.frame_data) begin
          if (mismatches < 10)
            $display("[%0t] mismatch: ", $realtime,
                     "expected st=%0d pid=%02h len=%0d data=%016h, ",
                     want.status, want.protected_id, want.data_length, want.frame_data,
                     "got st=%0d pid=%02h len=%0d data=%016h",
                     out_status, out_protected_id, out_data_length, out_frame_data);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    linsfr_pkg::cfg_t    c;
    bit                  got;
    linsfr_pkg::result_t res;
    int unsigned         goal;
    int unsigned         tick_div;

    // Directed frames. The first block runs with the registers as they come out of
    // reset, so every frame there ends in an error or an unknown id. The second block
    // uses a timeout of one tick, a respond-only id 0 and id 63 set for receive, respond
    // and the longest data length at once.
    script = '{
      '{linsfr_pkg::KIND_TICK, 8'h00, 1'b0, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'h00, 1'b0, 1'b1, linsfr_pkg::ST_BAD_BREAK,
        8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'h00, 1'b1, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'h54, 1'b0, 1'b1, linsfr_pkg::ST_BAD_SYNC,
        8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'h00, 1'b1, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'h55, 1'b0, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'hFF, 1'b0, 1'b1, linsfr_pkg::ST_PARITY,
        8'hFF, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'h00, 1'b1, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'h55, 1'b0, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'h80, 1'b0, 1'b1, linsfr_pkg::ST_UNKNOWN_ID,
        8'h80, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'h00, 1'b1, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_TICK, 8'hFF, 1'b1, 1'b1, linsfr_pkg::ST_TIMEOUT,
        8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'h00, 1'b1, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'h55, 1'b1, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'h80, 1'b0, 1'b1, linsfr_pkg::ST_RESPOND,
        8'h80, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'h00, 1'b1, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'h55, 1'b0, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'hBF, 1'b0, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'hFF, 1'b1, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'hFF, 1'b0, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'hFF, 1'b1, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'hFF, 1'b0, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'hFF, 1'b1, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'hFF, 1'b0, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'hFF, 1'b1, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'hFF, 1'b0, 1'b0, linsfr_pkg::ST_OK, 8'h00, 4'd0, 64'd0},
      '{linsfr_pkg::KIND_BYTE, 8'h00, 1'b0, 1'b1, linsfr_pkg::ST_OK,
        8'hBF, 4'd8, {64{1'b1}}},
      '{linsfr_pkg::KIND_BYTE, 8'hFF, 1'b1, 1'b1, linsfr_pkg::ST_BAD_BREAK,
        8'h00, 4'd0, 64'd0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (i == SCRIPT_RESET_ROWS) begin
        settle_idle();
        c = '{timeout_ticks: 8'd1, rx_mask: 64'd1 << 63,
              resp_mask: (64'd1 << 63) | 64'd1, len0_mask: 64'd1 << 63,
              len1_mask: 64'd1 << 63, len2_mask: 64'd1 << 63};
        program_regs(c);
      end
      drive_item(script[i].kind, script[i].rx_byte, script[i].ferr, got, res);
      if (script[i].fixed) begin
        res.status       = script[i].status;
        res.protected_id = script[i].pid;
        res.data_length  = script[i].len;
        res.frame_data   = script[i].data;
        awaited_results.push_back(res);
      end else if (got) begin
        awaited_results.push_back(res);
      end
    end

    // Random traffic under a series of register settings: every id receiving eight
    // bytes with the longest timeout, a zero timeout with no ids known, respond-only
    // ids with a one-tick timeout, one-byte frames, and random settings after that.
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        0: c = '{timeout_ticks: 8'd255, rx_mask: '1, resp_mask: '1,
                 len0_mask: '1, len1_mask: '1, len2_mask: '1};
        1: c = '{timeout_ticks: 8'd0, rx_mask: '0, resp_mask: '0,
                 len0_mask: '0, len1_mask: '0, len2_mask: '0};
        2: c = '{timeout_ticks: 8'd1, rx_mask: '0, resp_mask: '1,
                 len0_mask: '0, len1_mask: '0, len2_mask: '0};
        3: c = '{timeout_ticks: 8'($urandom_range(2, 40)),
                 rx_mask: {$urandom, $urandom}, resp_mask: {$urandom, $urandom},
                 len0_mask: '0, len1_mask: '0, len2_mask: '0};
        default: c = '{timeout_ticks: 8'($urandom_range(1, 60)),
                       rx_mask: {$urandom, $urandom}, resp_mask: {$urandom, $urandom},
                       len0_mask: {$urandom, $urandom}, len1_mask: {$urandom, $urandom},
                       len2_mask: {$urandom, $urandom}};
      endcase
      settle_idle();
      program_regs(c);
      quiet    = (s == NUM_SETTINGS - 1);
      tick_div = $urandom_range(3, 25);
      goal     = items_done + ITEMS_PER_SETTING;
      while (items_done < goal) begin
        random_frame(tick_div);
        // Now and then the sender holds off until the output side has caught up.
        if ($urandom_range(0, 39) == 0)
          settle_idle();
      end
      // Close any frame still open so the registers are rewritten with the block idle.
      while (frm_phase != linsfr_pkg::PH_IDLE)
        send_item(linsfr_pkg::KIND_BYTE, 8'hFF, 1'b0);
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d bus transactions and %0d frame status results over %0d %s",
             items_done, results_seen, NUM_SETTINGS + 2, "register settings.");
    $display("Statuses: ok %0d, respond %0d, break %0d, sync %0d, ",
             status_seen[linsfr_pkg::ST_OK], status_seen[linsfr_pkg::ST_RESPOND],
             status_seen[linsfr_pkg::ST_BAD_BREAK], status_seen[linsfr_pkg::ST_BAD_SYNC],
             "parity %0d, csum %0d, timeout %0d, unknown %0d",
             status_seen[linsfr_pkg::ST_PARITY], status_seen[linsfr_pkg::ST_CHECKSUM],
             status_seen[linsfr_pkg::ST_TIMEOUT], status_seen[linsfr_pkg::ST_UNKNOWN_ID]);
    if (awaited_results.size() != 0)
      $display("%0d predicted status transactions never arrived", awaited_results.size());
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/linsfr_pkg.sv
sv/linsfr_cfg_regs.sv
sv/linsfr_in_reg.sv
sv/linsfr_frame_fsm.sv
sv/linsfr_out_reg.sv
sv/lin_slave_frame_receiver.sv
sv/linsfr_checker.sv
dv/lin_slave_frame_receiver_tb.sv
